// ----- hw/rtl/chxy_pkg.sv -----
// Shared types, constants and the arctangent table for the compass heading block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package chxy_pkg;

  // Number of CORDIC rotation cells in the chain (legal range 8 to 24).
  localparam int CordicStages = 16;
  localparam int StageIdxW    = (CordicStages > 1) ? $clog2(CordicStages) : 1;

  // Datapath widths.
  localparam int FieldW     = 16;
  localparam int InputShift = 14;
  localparam int XyW        = 32;   // |x|,|y| stay below 1.65 * sqrt(2) * 2^29
  localparam int ZW         = 19;   // |z| stays below 2^18 (Q16 radians)
  localparam int ZFracDrop  = 3;    // Q16 -> Q13
  localparam int SumW       = 17;
  localparam int WrapW      = 18;

  // Angle constants.
  localparam int PiQ13      = 25736;
  localparam int TwoPiQ13   = 51472;
  localparam int HalfPiQ16  = 102944;
  localparam int Deg360Q7   = 46080;

  // Degrees = floor((h * 46080 + 25736) / 51472), reduced by the common factor 16
  // and computed as a multiply by a rounded-up reciprocal (exact for n < 2^28).
  localparam int DegMul   = Deg360Q7 / 16;
  localparam int DegDen   = TwoPiQ13 / 16;
  localparam int DegBias  = (TwoPiQ13 / 2) / 16;
  localparam int NW       = 28;
  localparam int DegShift = 40;
  localparam int RecipW   = 29;
  localparam int ProdW    = NW + RecipW;
  localparam logic [RecipW-1:0] DegRecip =
      RecipW'(((64'd1 << DegShift) + 64'(DegDen) - 64'd1) / 64'(DegDen));

  typedef struct packed {
    logic signed [FieldW-1:0] field_x;
    logic signed [FieldW-1:0] field_y;
  } in_item_t;

  typedef struct packed {
    logic [FieldW-1:0] heading_radians;
    logic [FieldW-1:0] heading_degrees;
  } out_item_t;

  // What one cell hands to the next.
  typedef struct packed {
    logic                  valid;
    logic                  zero;
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
  } cell_t;

  // atan(2^-i) in Q16 radians, rounded to nearest; zero past the table.
  function automatic logic signed [ZW-1:0] atan_q16(input logic [StageIdxW-1:0] idx);
    logic signed [ZW-1:0] a;
    a = '0;
    unique case (int'(idx))
      0:       a = ZW'(51472);
      1:       a = ZW'(30386);
      2:       a = ZW'(16055);
      3:       a = ZW'(8150);
      4:       a = ZW'(4091);
      5:       a = ZW'(2047);
      6:       a = ZW'(1024);
      7:       a = ZW'(512);
      8:       a = ZW'(256);
      9:       a = ZW'(128);
      10:      a = ZW'(64);
      11:      a = ZW'(32);
      12:      a = ZW'(16);
      13:      a = ZW'(8);
      14:      a = ZW'(4);
      15:      a = ZW'(2);
      16:      a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/chxy_prerot.sv -----
// Entry cell: scales the raw axis pair and folds the left half plane by +-pi/2.
// Depends on chxy_pkg.
`default_nettype none

module chxy_prerot (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire chxy_pkg::in_item_t data_i,
  output chxy_pkg::cell_t        cell_o
);

  logic signed [chxy_pkg::XyW-1:0] xs, ys;
  chxy_pkg::cell_t cell_d, cell_q;

  always_comb begin
    xs = chxy_pkg::XyW'(data_i.field_x) <<< chxy_pkg::InputShift;
    ys = chxy_pkg::XyW'(data_i.field_y) <<< chxy_pkg::InputShift;
    cell_d.valid = valid_i;
    cell_d.zero  = (data_i.field_x == '0) && (data_i.field_y == '0);
    cell_d.x     = xs;
    cell_d.y     = ys;
    cell_d.z     = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        cell_d.x = ys;
        cell_d.y = -xs;
        cell_d.z = chxy_pkg::ZW'(chxy_pkg::HalfPiQ16);
      end else begin
        cell_d.x = -ys;
        cell_d.y = xs;
        cell_d.z = chxy_pkg::ZW'(-chxy_pkg::HalfPiQ16);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

// ----- hw/rtl/chxy_cordic_cell.sv -----
// One CORDIC vectoring rotation; stage_i is tied to a constant per instance.
// Depends on chxy_pkg.
`default_nettype none

module chxy_cordic_cell (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire logic [chxy_pkg::StageIdxW-1:0]  stage_i,
  input  wire chxy_pkg::cell_t                 cell_i,
  output chxy_pkg::cell_t                      cell_o
);

  logic signed [chxy_pkg::XyW-1:0] xsh, ysh;
  logic signed [chxy_pkg::ZW-1:0]  ang;
  chxy_pkg::cell_t cell_d, cell_q;

  always_comb begin
    xsh    = cell_i.x >>> stage_i;
    ysh    = cell_i.y >>> stage_i;
    ang    = chxy_pkg::atan_q16(stage_i);
    cell_d = cell_i;
    // rotate toward the x axis
    if (cell_i.y < 0) begin
      cell_d.x = cell_i.x - ysh;
      cell_d.y = cell_i.y + xsh;
      cell_d.z = cell_i.z - ang;
    end else begin
      cell_d.x = cell_i.x + ysh;
      cell_d.y = cell_i.y - xsh;
      cell_d.z = cell_i.z + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

// ----- hw/rtl/chxy_post.sv -----
// Tail cells: angle to Q3.13 with clamp, declination add, wrap, radians to degrees.
// Four registered steps. Depends on chxy_pkg.
`default_nettype none

module chxy_post (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire chxy_pkg::cell_t                    cell_i,
  input  wire logic signed [chxy_pkg::FieldW-1:0] decl_i,
  output logic                                    valid_o,
  output chxy_pkg::out_item_t                     item_o
);

  logic [3:0] valid_q;

  // step 1: round, clamp, add declination
  logic signed [chxy_pkg::ZW-1:0]     zr;
  logic signed [chxy_pkg::FieldW-1:0] ang;
  logic signed [chxy_pkg::SumW-1:0]   sum_d, sum_q;

  always_comb begin
    zr = (cell_i.z + chxy_pkg::ZW'(4)) >>> chxy_pkg::ZFracDrop;
    if (cell_i.zero) begin
      ang = '0;
    end else if (zr > chxy_pkg::ZW'(chxy_pkg::PiQ13)) begin
      ang = chxy_pkg::FieldW'(chxy_pkg::PiQ13);
    end else if (zr < chxy_pkg::ZW'(-chxy_pkg::PiQ13)) begin
      ang = chxy_pkg::FieldW'(-chxy_pkg::PiQ13);
    end else begin
      ang = zr[chxy_pkg::FieldW-1:0];
    end
    sum_d = chxy_pkg::SumW'(ang) + chxy_pkg::SumW'(decl_i);
  end

  // step 2: single wrap into [0, 2pi]; exactly 2pi is kept
  logic signed [chxy_pkg::WrapW-1:0] wrap;
  logic [chxy_pkg::FieldW-1:0]       h_d, h_q, h2_q, h3_q;

  always_comb begin
    wrap = chxy_pkg::WrapW'(sum_q);
    if (wrap < 0) begin
      wrap = wrap + chxy_pkg::WrapW'(chxy_pkg::TwoPiQ13);
    end else if (wrap > chxy_pkg::WrapW'(chxy_pkg::TwoPiQ13)) begin
      wrap = wrap - chxy_pkg::WrapW'(chxy_pkg::TwoPiQ13);
    end
    h_d = wrap[chxy_pkg::FieldW-1:0];
  end

  // step 3: scaled numerator; step 4: reciprocal multiply
  logic [chxy_pkg::NW-1:0]     n_d, n_q;
  logic [chxy_pkg::ProdW-1:0]  prod;
  logic [chxy_pkg::FieldW-1:0] deg_q;

  assign n_d  = chxy_pkg::NW'(h2_q) * chxy_pkg::NW'(chxy_pkg::DegMul)
              + chxy_pkg::NW'(chxy_pkg::DegBias);
  assign prod = chxy_pkg::ProdW'(n_q) * chxy_pkg::ProdW'(chxy_pkg::DegRecip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], cell_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
      h2_q  <= h_d;
      n_q   <= n_d;
      h3_q  <= h2_q;
      h_q   <= h3_q;
      deg_q <= prod[chxy_pkg::DegShift +: chxy_pkg::FieldW];
    end
  end

  assign item_o  = '{heading_radians: h_q, heading_degrees: deg_q};
  assign valid_o = valid_q[3];

endmodule

`default_nettype wire

// ----- hw/rtl/compass_heading_from_xy.sv -----
// Top level of the compass heading block: CORDIC cell chain, tail cells and output buffer.
// Depends on chxy_pkg, chxy_prerot, chxy_cordic_cell and chxy_post.
`default_nettype none

// Compass heading from a pair of magnetometer axis readings. Each input beat carries
// signed field_x and field_y; each output beat carries the heading atan2(y, x) plus
// the declination register, wrapped once into [0, 2pi], as unsigned Q3.13 radians
// and as unsigned Q9.7 degrees (2pi maps to exactly 360.0). A zero vector gives an
// angle of 0, so the heading is then the wrapped declination. The datapath is a row
// of identical CORDIC cells, one rotation per cell, fed by an entry cell that folds
// the left half plane and followed by four tail cells; every cell moves its beat to
// the next one whenever the row advances, so one beat is accepted per cycle while
// the skid register is empty. The whole row advances together; a two-entry output
// buffer (output register plus skid register) lets new beats enter while a result
// waits, and in_ready_o drops only when both entries are full. The declination port
// is always ready; a write is saturated to +-pi and should only be issued while no
// beat is in flight.

module compass_heading_from_xy (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire chxy_pkg::in_item_t                 in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output chxy_pkg::out_item_t                     out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic signed [chxy_pkg::FieldW-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Declination register, saturated on write.
  // ---------------------------------------------------------------------------
  logic signed [chxy_pkg::FieldW-1:0] decl_d, decl_q;

  always_comb begin
    if (cfg_data_i > chxy_pkg::FieldW'(chxy_pkg::PiQ13)) begin
      decl_d = chxy_pkg::FieldW'(chxy_pkg::PiQ13);
    end else if (cfg_data_i < chxy_pkg::FieldW'(-chxy_pkg::PiQ13)) begin
      decl_d = chxy_pkg::FieldW'(-chxy_pkg::PiQ13);
    end else begin
      decl_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_q <= '0;
    end else if (cfg_valid_i) begin
      decl_q <= decl_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Cell row. The row shifts whenever the skid register is free.
  // ---------------------------------------------------------------------------
  logic                row_en;
  chxy_pkg::cell_t     chain [chxy_pkg::CordicStages+1];
  logic                tail_valid;
  chxy_pkg::out_item_t tail_item;

  chxy_prerot u_prerot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (row_en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cell_o  (chain[0])
  );

  for (genvar g = 0; g < chxy_pkg::CordicStages; g++) begin : g_cell
    chxy_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (row_en),
      .stage_i (chxy_pkg::StageIdxW'(g)),
      .cell_i  (chain[g]),
      .cell_o  (chain[g+1])
    );
  end

  chxy_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (row_en),
    .cell_i  (chain[chxy_pkg::CordicStages]),
    .decl_i  (decl_q),
    .valid_o (tail_valid),
    .item_o  (tail_item)
  );

  // ---------------------------------------------------------------------------
  // Output register plus skid register.
  // ---------------------------------------------------------------------------
  logic                out_valid_q, skid_valid_q;
  chxy_pkg::out_item_t out_q, skid_q;
  logic                push, pop;

  assign row_en     = !skid_valid_q;
  assign in_ready_o = row_en;
  assign push       = row_en && tail_valid;
  assign pop        = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= tail_item;
      end else begin
        out_q <= tail_item;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/chxy_checker.sv -----
// Port-level checks for the compass heading block, bound to the top level.
// Depends on chxy_pkg and compass_heading_from_xy.
`default_nettype none

module chxy_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_ready_o,
  input wire logic                               out_valid_o,
  input wire logic                               out_ready_i,
  input wire chxy_pkg::out_item_t                out_data_o
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // input back-pressure only while a result is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  a_rad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.heading_radians <= 16'(chxy_pkg::TwoPiQ13))
    else $error("heading radians out of range");

  a_deg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.heading_degrees <= 16'(chxy_pkg::Deg360Q7))
    else $error("heading degrees out of range");

  // zero radians must map to zero degrees
  a_zero_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.heading_radians == '0) |-> out_data_o.heading_degrees == '0)
    else $error("zero heading gave nonzero degrees");

endmodule

bind compass_heading_from_xy chxy_checker u_chxy_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for compass_heading_from_xy: drives (x, y) beats and declination
// writes, predicts each heading in fixed point and checks every output beat.
// Depends on chxy_pkg and the compass_heading_from_xy RTL.

module testbench;

  // The limit sits well above any correct run; it only catches hangs.
  localparam int unsigned CycleLimit = 400000;
  localparam int          DrainWait  = chxy_pkg::CordicStages + 10;

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_ready_o;
  chxy_pkg::in_item_t                 in_data_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  chxy_pkg::out_item_t                out_data_o;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic signed [chxy_pkg::FieldW-1:0] cfg_data_i;

  // Headings still owed by the block, oldest first.
  chxy_pkg::out_item_t      expected_headings[$];
  // Declination as the block should hold it after saturation.
  int                       declination_q13;
  int                       error_count = 0;
  int unsigned              cycle_count = 0;
  // Random idling on the input side and stalls on the output side.
  bit                       idle_in  = 1'b0;
  bit                       stall_out = 1'b0;

  compass_heading_from_xy u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // 4 ns period: high 2, low 2.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hang guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // atan(2^-stage) in Q16 radians, rounded to nearest; zero beyond the table.
  function automatic longint arctan_q16(int stage);
    longint a;
    case (stage)
      0:       a = 51472;
      1:       a = 30386;
      2:       a = 16055;
      3:       a = 8150;
      4:       a = 4091;
      5:       a = 2047;
      6:       a = 1024;
      7:       a = 512;
      8:       a = 256;
      9:       a = 128;
      10:      a = 64;
      11:      a = 32;
      12:      a = 16;
      13:      a = 8;
      14:      a = 4;
      15:      a = 2;
      16:      a = 1;
      default: a = 0;
    endcase
    return a;
  endfunction

  // Heading for one (x, y) pair under the given declination.
  function automatic chxy_pkg::out_item_t predict_heading(
      logic signed [chxy_pkg::FieldW-1:0] fx,
      logic signed [chxy_pkg::FieldW-1:0] fy,
      int decl);
    longint              x, y, z, nx, ang, h, deg;
    chxy_pkg::out_item_t r;
    x = longint'(fx) * 16384;
    y = longint'(fy) * 16384;
    z = 0;
    if (fx == 0 && fy == 0) begin
      ang = 0;
    end else begin
      // Left half plane: fold into the right half by a quarter turn first.
      if (x < 0) begin
        if (y >= 0) begin
          nx = y; y = -x; x = nx; z = chxy_pkg::HalfPiQ16;
        end else begin
          nx = -y; y = x; x = nx; z = -chxy_pkg::HalfPiQ16;
        end
      end
      // Vectoring: drive y toward zero, accumulating the rotation in z.
      for (int i = 0; i < chxy_pkg::CordicStages; i++) begin
        if (y < 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - arctan_q16(i);
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + arctan_q16(i);
        end
        x = nx;
      end
      // Q16 -> Q13 with rounding, then clamp the overshoot to +-pi.
      ang = (z + 4) >>> 3;
      if (ang > chxy_pkg::PiQ13)  ang = chxy_pkg::PiQ13;
      if (ang < -chxy_pkg::PiQ13) ang = -chxy_pkg::PiQ13;
    end
    // One wrap; exactly 2pi is kept as is.
    h = ang + decl;
    if (h < 0)                  h = h + chxy_pkg::TwoPiQ13;
    if (h > chxy_pkg::TwoPiQ13) h = h - chxy_pkg::TwoPiQ13;
    deg = (h * chxy_pkg::Deg360Q7 + chxy_pkg::TwoPiQ13 / 2) / chxy_pkg::TwoPiQ13;
    r.heading_radians = h[chxy_pkg::FieldW-1:0];
    r.heading_degrees = deg[chxy_pkg::FieldW-1:0];
    return r;
  endfunction

  // Field value biased toward zero, tiny magnitudes and the rails.
  function automatic logic signed [chxy_pkg::FieldW-1:0] random_field();
    logic signed [chxy_pkg::FieldW-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = chxy_pkg::FieldW'(int'($urandom_range(0, 16)) - 8);
      2:       v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: v = chxy_pkg::FieldW'($urandom);
    endcase
    return v;
  endfunction

  // Output side pacing: random stall bursts while enabled.
  initial begin : sink_pacing
    int burst;
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (stall_out && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 10);
        out_ready_i = 1'b0;
        repeat (burst) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
    end
  end

  // Result checker: every accepted output beat against the oldest prediction.
  always @(posedge clk_i) begin
    chxy_pkg::out_item_t exp_h;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_headings.size() == 0) begin
        $error("unexpected heading beat: radians %0d degrees %0d",
               out_data_o.heading_radians, out_data_o.heading_degrees);
        error_count++;
      end else begin
        exp_h = expected_headings.pop_front();
        if (out_data_o.heading_radians !== exp_h.heading_radians) begin
          $error("heading_radians: expected %0d, got %0d",
                 exp_h.heading_radians, out_data_o.heading_radians);
          error_count++;
        end
        if (out_data_o.heading_degrees !== exp_h.heading_degrees) begin
          $error("heading_degrees: expected %0d, got %0d",
                 exp_h.heading_degrees, out_data_o.heading_degrees);
          error_count++;
        end
      end
    end
  end

  // One input beat; an optional idle burst first. Returns at the accepting edge.
  task automatic send_sample(input logic signed [chxy_pkg::FieldW-1:0] fx,
                             input logic signed [chxy_pkg::FieldW-1:0] fy);
    int gap;
    if (idle_in && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i         = 1'b1;
    in_data_i.field_x  = fx;
    in_data_i.field_y  = fy;
    do @(posedge clk_i); while (!in_ready_o);
    expected_headings.push_back(predict_heading(fx, fy, declination_q13));
  endtask

  // Stop sending and wait until the pipe is empty.
  task automatic drain_pipe();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_headings.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Declination write, only with the pipe empty. Model saturates like the block.
  task automatic write_declination(input logic signed [chxy_pkg::FieldW-1:0] val);
    int d;
    drain_pipe();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    d = val;
    if (d > chxy_pkg::PiQ13)  d = chxy_pkg::PiQ13;
    if (d < -chxy_pkg::PiQ13) d = -chxy_pkg::PiQ13;
    declination_q13 = d;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Axes, rails, zero vector and the left-half-plane fold at reset declination.
  task automatic test_axes_and_octants();
    send_sample(16'sd0, 16'sd0);          // zero vector
    send_sample(16'sh7fff, 16'sd0);
    send_sample(16'sh8000, 16'sd0);       // negative x axis gives +pi
    send_sample(-16'sd1, 16'sd0);
    send_sample(16'sd0, 16'sh7fff);
    send_sample(16'sd0, 16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(-16'sd1, -16'sd1);
    send_sample(16'sd1, -16'sd1);
    send_sample(16'sh8000, -16'sd1);      // just below the negative x axis
  endtask

  // Declination saturation and both wrap directions, including exactly 2pi.
  task automatic test_declination_wrap();
    write_declination(16'sh7fff);         // saturates to +pi
    send_sample(16'sd0, 16'sd0);
    send_sample(-16'sd1, 16'sd0);         // pi + pi lands on 2pi, kept
    send_sample(-16'sd5, -16'sd1);
    write_declination(16'sh8000);         // saturates to -pi
    send_sample(16'sd0, 16'sd0);
    send_sample(-16'sd1, 16'sd0);         // -pi + pi lands on 0
    send_sample(16'sd0, -16'sd1);         // below zero, wraps up
    send_sample(-16'sd3, -16'sd1);
    write_declination(16'(chxy_pkg::PiQ13));
    send_sample(16'sd3, 16'sd4);
    write_declination(16'(-chxy_pkg::PiQ13));
    send_sample(16'sd3, -16'sd4);
    send_sample(16'sh8000, 16'sh8000);
  endtask

  // Random pairs over several declinations with idling on both sides.
  task automatic test_random_headings();
    logic signed [chxy_pkg::FieldW-1:0] d;
    idle_in   = 1'b1;
    stall_out = 1'b1;
    for (int phase = 0; phase < 8; phase++) begin
      // Mix in-range values with out-of-range ones that must saturate.
      d = ($urandom_range(0, 1) == 0)
          ? chxy_pkg::FieldW'($urandom)
          : chxy_pkg::FieldW'(int'($urandom_range(0, 2 * chxy_pkg::PiQ13))
                              - chxy_pkg::PiQ13);
      write_declination(d);
      repeat (100) send_sample(random_field(), random_field());
    end
  endtask

  // Closing stretch: full-rate beats, no idling or stalls.
  task automatic test_back_to_back();
    idle_in   = 1'b0;
    stall_out = 1'b0;
    write_declination(chxy_pkg::FieldW'($urandom));
    repeat (100) send_sample(random_field(), random_field());
    write_declination(16'sd0);
    repeat (100) send_sample(random_field(), random_field());
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    declination_q13 = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_axes_and_octants();
    test_declination_wrap();
    test_random_headings();
    test_back_to_back();
    drain_pipe();

    if (error_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/chxy_pkg.sv
hw/rtl/chxy_prerot.sv
hw/rtl/chxy_cordic_cell.sv
hw/rtl/chxy_post.sv
hw/rtl/compass_heading_from_xy.sv
hw/rtl/chxy_checker.sv
bench/testbench.sv
